[rtl/rppd_pkg.sv]
package rppd_pkg;

   localparam int unsigned LevelWidth    = 18;
   localparam int unsigned StrengthWidth = 6;
   localparam int unsigned CountWidth    = 8;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_PULSE  = 2'd1;
   localparam logic [1:0] CMD_QUEUE  = 2'd2;
   localparam logic [1:0] CMD_CANCEL = 2'd3;

   localparam logic [7:0]            STRENGTH_MAX = 8'h30;
   localparam logic [LevelWidth-1:0] RISE_STEP    = 18'h00aaa;
   localparam logic [LevelWidth-1:0] DECAY_STEP   = 18'h00375;
   localparam logic [LevelWidth-1:0] LEVEL_PIN    = 18'h10000;
   localparam logic [LevelWidth-1:0] LEVEL_MAX    = 18'd199338;

   typedef struct packed {
      logic [CountWidth-1:0] pulses_left;
      logic [LevelWidth-1:0] energy_level;
      logic                  pulse_active;
      logic                  motor_on;
   } rsp_word_type;

   typedef struct packed {
      logic [LevelWidth-1:0] target;
      logic                  rising;
   } pulse_type;

   function automatic logic [StrengthWidth-1:0] clamp_strength(input logic [7:0] s);
      clamp_strength = (s > STRENGTH_MAX) ? STRENGTH_MAX[StrengthWidth-1:0]
                                          : s[StrengthWidth-1:0];
   endfunction

   // target = strength * 4096, raised only while a rise is running
   function automatic pulse_type start_pulse(input logic                  rising,
                                             input logic [LevelWidth-1:0] target,
                                             input logic [LevelWidth-1:0] level,
                                             input logic [StrengthWidth-1:0] s);
      logic [LevelWidth-1:0] t;
      pulse_type             p;
      t = {s, 12'd0};
      p.target = (!rising || target <= t) ? t : target;
      p.rising = rising || (level < p.target);
      start_pulse = p;
   endfunction

endpackage

[rtl/rumble_pulse_pattern_driver.sv]
// Haptic pulse driver for a rumble motor.
// req channel: one word per command; req_tuser holds cmd[1:0] and tdata from
// bit 0 holds intensity[7:0], pulse_count[15:8], gap_ticks[23:16]. cmd 0 is a
// timer tick, 1 starts a single pulse, 2 queues a pattern, 3 cancels everything.
// rsp channel: exactly one word per command, in order; tdata from bit 0 holds
// motor_on, pulse_active, energy_level[19:2], pulses_left[27:20].
// csr port: csr_we writes drive_enable from csr_wdata and forces the motor off;
// write it only while no command is in flight.
// Commands are processed combinationally between the request handshake and a two-word
// result queue; the result shows on rsp in the cycle after the request is taken unless
// an older word still waits, and a command is accepted every cycle the queue is not full.
// When the receiver stalls, the queue holds up to two words; req_tready drops
// only when both are full, and rises again once the registered fill drops after one is taken.
// Synchronous reset clears the energy state, the pattern, drive_enable and
// empties the result queue.
module rumble_pulse_pattern_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // intensity, pulse_count, gap_ticks
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // motor_on, pulse_active, energy_level, pulses_left
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import rppd_pkg::*;

   logic                     drive_enable_ff, drive_enable_in;
   logic                     rising_ff, rising_in;
   logic [LevelWidth-1:0]    level_ff, level_in;
   logic [LevelWidth-1:0]    target_ff, target_in;
   logic                     motor_drive_ff, motor_drive_in;
   logic [CountWidth-1:0]    qcount_ff, qcount_in;
   logic [CountWidth-1:0]    qgap_ff, qgap_in;
   logic [CountWidth-1:0]    qdelay_ff, qdelay_in;
   logic [StrengthWidth-1:0] qstrength_ff, qstrength_in;

   logic [1:0]   fill_ff, fill_in;
   rsp_word_type head_ff, head_in;
   rsp_word_type skid_ff, skid_in;

   logic         push, pop;
   logic [1:0]   cmd;
   logic [7:0]   intensity, pulse_count, gap_ticks;
   rsp_word_type word_new;

   assign cmd         = req_tuser;
   assign intensity   = req_tdata[7:0];
   assign pulse_count = req_tdata[15:8];
   assign gap_ticks   = req_tdata[23:16];

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (fill_ff != 2'd0);
   assign rsp_tdata  = {4'd0, head_ff};

   always_comb begin
      logic [LevelWidth-1:0] lvl_up;
      pulse_type             p;
      rising_in       = rising_ff;
      level_in        = level_ff;
      target_in       = target_ff;
      motor_drive_in  = motor_drive_ff;
      qcount_in       = qcount_ff;
      qgap_in         = qgap_ff;
      qdelay_in       = qdelay_ff;
      qstrength_in    = qstrength_ff;
      drive_enable_in = drive_enable_ff;
      lvl_up          = level_ff + RISE_STEP;
      p               = '0;
      if (push) begin
         case (cmd)
            CMD_TICK: begin
               if (rising_ff) begin
                  motor_drive_in = drive_enable_ff;
                  level_in       = lvl_up;
                  if (lvl_up >= target_ff) begin
                     rising_in = 1'b0;
                     if (target_ff > LEVEL_PIN) begin
                        level_in = LEVEL_PIN;
                     end
                  end
               end else begin
                  motor_drive_in = 1'b0;
                  level_in = (level_ff > DECAY_STEP) ? (level_ff - DECAY_STEP) : '0;
               end
               // next queued pulse once the motor has settled at zero
               if (!rising_in && level_in == '0 && qcount_ff != '0) begin
                  if (qdelay_ff != '0) begin
                     qdelay_in = qdelay_ff - CountWidth'(1);
                  end else begin
                     p = start_pulse(rising_in, target_ff, level_in, qstrength_ff);
                     target_in = p.target;
                     rising_in = p.rising;
                     qcount_in = qcount_ff - CountWidth'(1);
                     qdelay_in = qgap_ff;
                  end
               end
            end
            CMD_PULSE: begin
               qcount_in    = '0;
               qgap_in      = '0;
               qdelay_in    = '0;
               qstrength_in = '0;
               p = start_pulse(rising_ff, target_ff, level_ff, clamp_strength(intensity));
               target_in = p.target;
               rising_in = p.rising;
            end
            CMD_QUEUE: begin
               qcount_in    = '0;
               qgap_in      = '0;
               qdelay_in    = '0;
               qstrength_in = '0;
               if (pulse_count != '0) begin
                  p = start_pulse(rising_ff, target_ff, level_ff,
                                  clamp_strength(intensity));
                  target_in = p.target;
                  rising_in = p.rising;
                  if (pulse_count > 8'd1) begin
                     qcount_in    = pulse_count - 8'd1;
                     qgap_in      = gap_ticks;
                     qdelay_in    = gap_ticks;
                     qstrength_in = clamp_strength(intensity);
                  end
               end
            end
            default: begin
               motor_drive_in = 1'b0;
               rising_in      = 1'b0;
               level_in       = '0;
               target_in      = '0;
               qcount_in      = '0;
               qgap_in        = '0;
               qdelay_in      = '0;
               qstrength_in   = '0;
            end
         endcase
      end
      if (csr_we) begin
         drive_enable_in = csr_wdata;
         motor_drive_in  = 1'b0;
      end
   end

   always_comb begin
      word_new.motor_on     = motor_drive_in;
      word_new.pulse_active = rising_in;
      word_new.energy_level = level_in;
      word_new.pulses_left  = qcount_in;
   end

   // two-word result queue: head drives rsp, skid catches a word during a stall
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
         if (fill_ff == 2'd0) begin
            head_in = word_new;
         end else begin
            skid_in = word_new;
         end
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
         head_in = skid_ff;
      end else if (push && pop) begin
         if (fill_ff == 2'd1) begin
            head_in = word_new;
         end else begin
            head_in = skid_ff;
            skid_in = word_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_enable_ff <= 1'b0;
         rising_ff       <= 1'b0;
         level_ff        <= '0;
         target_ff       <= '0;
         motor_drive_ff  <= 1'b0;
         qcount_ff       <= '0;
         qgap_ff         <= '0;
         qdelay_ff       <= '0;
         qstrength_ff    <= '0;
         fill_ff         <= 2'd0;
      end else begin
         drive_enable_ff <= drive_enable_in;
         rising_ff       <= rising_in;
         level_ff        <= level_in;
         target_ff       <= target_in;
         motor_drive_ff  <= motor_drive_in;
         qcount_ff       <= qcount_in;
         qgap_ff         <= qgap_in;
         qdelay_ff       <= qdelay_in;
         qstrength_ff    <= qstrength_in;
         fill_ff         <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("result queue fill out of range");

   a_rise_below_target: assert property (@(posedge clock) disable iff (reset)
      rising_ff |-> (level_ff < target_ff))
      else $error("rising with level at or above target");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_MAX)
      else $error("energy level out of range");

   a_disabled_motor_off: assert property (@(posedge clock) disable iff (reset)
      !drive_enable_ff |-> !motor_drive_ff)
      else $error("motor driven while disabled");

   a_csr_motor_off: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !motor_drive_ff)
      else $error("motor not forced off by register write");
`endif

endmodule
